/* rtl/tdp_pkg.sv */
// Package for the trial division prime test unit.
// Holds the value width, derived widths and the controller/datapath structs.
// No dependencies.
`default_nettype none

package tdp_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);
    localparam int REM_W       = VALUE_WIDTH + 1;
    localparam int SQ_W        = VALUE_WIDTH + 2;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic lt2;
        logic sq_gt;
        logic cnt_zero;
        logic rem_zero;
    } t_stat;

endpackage

`default_nettype wire

/* rtl/tdp_dp.sv */
// Datapath: magnitude, trial divisor, running square and bit-serial remainder.
// Depends on tdp_pkg.
`default_nettype none

module tdp_dp (
    input  wire logic                               i_clk,
    input  wire tdp_pkg::t_cmd                      i_cmd,
    input  wire logic [tdp_pkg::VALUE_WIDTH-1:0]    i_value,
    output tdp_pkg::t_stat                          o_stat
);

    logic [tdp_pkg::VALUE_WIDTH-1:0] r_mag, n_mag;
    logic [tdp_pkg::VALUE_WIDTH-1:0] r_div, n_div;
    logic [tdp_pkg::SQ_W-1:0]        r_sq, n_sq;
    logic [tdp_pkg::REM_W-1:0]       r_rem, n_rem;
    logic [tdp_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic [tdp_pkg::REM_W-1:0]       w_shift;
    logic [tdp_pkg::REM_W-1:0]       w_div_ext;

    assign w_shift   = {r_rem[tdp_pkg::VALUE_WIDTH-1:0], r_mag[r_cnt]};
    assign w_div_ext = {1'b0, r_div};

    always_comb begin
        n_mag = r_mag;
        n_div = r_div;
        n_sq  = r_sq;
        n_rem = r_rem;
        n_cnt = r_cnt;
        if (i_cmd.load) begin
            n_mag = i_value[tdp_pkg::VALUE_WIDTH-1] ? (~i_value + 1'b1) : i_value;
            n_div = tdp_pkg::VALUE_WIDTH'(2);
            n_sq  = tdp_pkg::SQ_W'(4);
        end
        if (i_cmd.div_start) begin
            n_rem = '0;
            n_cnt = tdp_pkg::CNT_W'(tdp_pkg::VALUE_WIDTH - 1);
        end
        if (i_cmd.div_step) begin
            n_rem = (w_shift >= w_div_ext) ? (w_shift - w_div_ext) : w_shift;
            n_cnt = r_cnt - 1'b1;
        end
        if (i_cmd.advance) begin
            n_div = r_div + 1'b1;
            n_sq  = r_sq + {1'b0, r_div, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_div <= n_div;
        r_sq  <= n_sq;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
    end

    assign o_stat.lt2      = (r_mag < tdp_pkg::VALUE_WIDTH'(2));
    assign o_stat.sq_gt    = (r_sq > {2'b00, r_mag});
    assign o_stat.cnt_zero = (r_cnt == '0);
    assign o_stat.rem_zero = (r_rem == '0);

endmodule

`default_nettype wire

/* rtl/tdp_ctrl.sv */
// Controller: sequences the trial divisions and owns the result register.
// Depends on tdp_pkg.
`default_nettype none

module tdp_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    output logic                o_m_tvalid,
    input  wire logic           i_m_tready,
    output logic                o_is_prime,
    output tdp_pkg::t_cmd       o_cmd,
    input  wire tdp_pkg::t_stat i_stat
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_res, n_res;
    logic       r_out_valid, n_out_valid;
    logic       r_out_data, n_out_data;

    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        o_cmd       = '0;
        o_s_tready  = 1'b0;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.lt2) begin
                    n_res   = 1'b0;
                    n_state = S_DONE;
                end else if (i_stat.sq_gt) begin
                    n_res   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.cnt_zero) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.rem_zero) begin
                    n_res   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_is_prime = r_out_data;

endmodule

`default_nettype wire

/* rtl/trial_division_prime_test_unit.sv */
// Latency: magnitudes below 2 or equal to 2 or 3 are decided without a trial division;
// otherwise it grows with the number k of trial divisors tried, until one divides or the
// square bound ends the search (k up to about 46340 at 32 bits), and is set by the
// bit-serial remainder loop; a stalled result word adds its stall.
// Throughput: one word in flight; the next word is taken once the result is registered.
// Reset: synchronous active-low, clears the controller state and output valid.
`default_nettype none

module trial_division_prime_test_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  wire logic [tdp_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,  // [31:0] value
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    output logic [tdp_pkg::OUT_TDATA_W-1:0]         o_m_axis_tdata   // [0] is_prime, zero pad
);

    tdp_pkg::t_cmd  w_cmd;
    tdp_pkg::t_stat w_stat;
    logic           w_is_prime;

    tdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_is_prime (w_is_prime),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    tdp_dp u_dp (
        .i_clk   (i_clk),
        .i_cmd   (w_cmd),
        .i_value (i_s_axis_tdata[tdp_pkg::VALUE_WIDTH-1:0]),
        .o_stat  (w_stat)
    );

    assign o_m_axis_tdata = {{(tdp_pkg::OUT_TDATA_W-1){1'b0}}, w_is_prime};

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted while a word is in progress");

    a_no_div_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !(w_cmd.div_step || w_cmd.div_start || w_cmd.advance))
        else $error("divider active while ready for input");
`endif

endmodule

`default_nettype wire
